// ===== design/modbus_slave_register_engine_macros.svh =====
// Assertion macros shared by the register engine modules.
`ifndef MODBUS_SLAVE_REGISTER_ENGINE_MACROS_SVH
`define MODBUS_SLAVE_REGISTER_ENGINE_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define MSRE_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("msre check failed");

// Check a condition in the cycle after its trigger.
`define MSRE_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("msre check failed");

`endif

// ===== design/msre_pkg.sv =====
// Shared types, codes and constants of the Modbus slave register engine.
package msre_pkg;

    localparam int HOLD_DEPTH_DEF  = 32;
    localparam int INPUT_DEPTH_DEF = 32;

    localparam logic [7:0] FC_READ_HOLD   = 8'h03;
    localparam logic [7:0] FC_READ_INPUT  = 8'h04;
    localparam logic [7:0] FC_WRITE_MULTI = 8'h10;
    localparam logic [7:0] EXC_FLAG       = 8'h80;

    localparam logic [1:0] EXC_NONE     = 2'd0;
    localparam logic [1:0] EXC_FUNCTION = 2'd1;
    localparam logic [1:0] EXC_ADDRESS  = 2'd2;

    localparam logic [7:0] SLAVE_ADDR_RESET = 8'd1;

    typedef enum logic [1:0] {
        OP_HEADER,
        OP_WRITE_WORD,
        OP_LOAD_INPUT,
        OP_LOAD_HOLD
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EMIT,
        ST_RD_ISSUE,
        ST_RD_DATA
    } state_t;

    typedef enum logic [1:0] {
        EMIT_EXC,
        EMIT_RD_HDR,
        EMIT_WR_ECHO,
        EMIT_DATA
    } emit_t;

    typedef struct packed {
        logic  take;
        logic  hdr_clear;
        logic  wr_setup;
        logic  wr_word;
        logic  load_in;
        logic  load_hold;
        logic  rd_setup;
        logic  rd_issue;
        logic  emit;
        emit_t emit_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    addressed;
        logic    fn_legal;
        logic    range_ok;
        logic    is_write;
        logic    count_zero;
        logic    wr_pending;
        logic    wr_last;
        logic    rd_more;
        logic    slot_free;
    } dp_status_t;

    // Address width of a store; at least one bit.
    function automatic int addr_width(input int depth);
        int w;
        w = (depth > 1) ? $clog2(depth) : 1;
        return w;
    endfunction

endpackage

// ===== design/msre_store.sv =====
// Register store: one write port, one registered read port, per-entry valid bits.
module msre_store #(
    parameter int DEPTH = msre_pkg::HOLD_DEPTH_DEF,
    parameter int AW    = msre_pkg::addr_width(msre_pkg::HOLD_DEPTH_DEF)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0]      mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [15:0]      rd_word_reg;
    logic             rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // Entries never written read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_word_reg : 16'd0;

endmodule

// ===== design/msre_datapath.sv =====
// Datapath: request latch, checks, write and read pointers, stores, output register.
`include "modbus_slave_register_engine_macros.svh"

module msre_datapath #(
    parameter int HOLD_DEPTH  = msre_pkg::HOLD_DEPTH_DEF,
    parameter int INPUT_DEPTH = msre_pkg::INPUT_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  msre_pkg::ctrl_cmd_t   cmd,
    output msre_pkg::dp_status_t  sts,
    input  logic [1:0]            opcode,
    input  logic [7:0]            dest_address,
    input  logic [7:0]            function_code,
    input  logic [15:0]           start_address,
    input  logic [15:0]           register_count,
    input  logic [15:0]           data_word,
    input  logic [4:0]            local_index,
    input  logic                  cfg_valid,
    input  logic [7:0]            slave_address,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_kind,
    output logic [7:0]            out_station,
    output logic [7:0]            out_function,
    output logic [1:0]            exception_code,
    output logic [15:0]           field_a,
    output logic [15:0]           field_b,
    output logic [15:0]           reg_word,
    output logic                  last
);

    localparam int HAW  = msre_pkg::addr_width(HOLD_DEPTH);
    localparam int IAW  = msre_pkg::addr_width(INPUT_DEPTH);
    localparam int HCW  = $clog2(HOLD_DEPTH + 1);
    localparam int MAXD = (HOLD_DEPTH > INPUT_DEPTH) ? HOLD_DEPTH : INPUT_DEPTH;
    localparam int RAW  = $clog2(MAXD + 1);
    localparam logic [16:0] HOLD_LIM  = 17'(HOLD_DEPTH);
    localparam logic [16:0] INPUT_LIM = 17'(INPUT_DEPTH);

    // Latched input beat
    msre_pkg::opcode_t op_reg;
    logic [7:0]        dest_reg;
    logic [7:0]        fn_reg;
    logic [15:0]       start_reg;
    logic [15:0]       count_reg;
    logic [15:0]       word_reg;
    logic [4:0]        idx_reg;

    logic [7:0]        slave_address_reg;

    // Write-multiple state
    logic              wr_pending_reg, wr_pending_next;
    logic [HAW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [HCW-1:0]    wr_left_reg, wr_left_next;
    logic [15:0]       saved_start_reg, saved_start_next;
    logic [15:0]       saved_count_reg, saved_count_next;

    // Read state
    logic [RAW-1:0]    rd_addr_reg, rd_addr_next;
    logic [RAW-1:0]    rd_left_reg, rd_left_next;
    logic              rd_input_reg, rd_input_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic [7:0]        out_station_reg;
    logic [7:0]        out_function_reg, out_function_next;
    logic [1:0]        exception_code_reg, exception_code_next;
    logic [15:0]       field_a_reg, field_a_next;
    logic [15:0]       field_b_reg, field_b_next;
    logic [15:0]       reg_word_reg, reg_word_next;
    logic              last_reg, last_next;

    logic              fn_rd_hold, fn_rd_input, fn_write;
    logic [16:0]       span;
    logic              idx_in_hold, idx_in_input;

    logic              hold_wr_en, hold_rd_en;
    logic [HAW-1:0]    hold_wr_addr;
    logic [15:0]       hold_rd_data;
    logic              input_wr_en, input_rd_en;
    logic [15:0]       input_rd_data;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg    <= msre_pkg::opcode_t'(opcode);
            dest_reg  <= dest_address;
            fn_reg    <= function_code;
            start_reg <= start_address;
            count_reg <= register_count;
            word_reg  <= data_word;
            idx_reg   <= local_index;
        end
    end

    // Request checks
    always_comb
    begin
        fn_rd_hold   = (fn_reg == msre_pkg::FC_READ_HOLD);
        fn_rd_input  = (fn_reg == msre_pkg::FC_READ_INPUT);
        fn_write     = (fn_reg == msre_pkg::FC_WRITE_MULTI);
        span         = {1'b0, start_reg} + {1'b0, count_reg};
        idx_in_hold  = (32'(idx_reg) < HOLD_DEPTH);
        idx_in_input = (32'(idx_reg) < INPUT_DEPTH);

        sts.op         = op_reg;
        sts.addressed  = (dest_reg == slave_address_reg) || (dest_reg == 8'd0);
        sts.fn_legal   = fn_rd_hold || fn_rd_input || fn_write;
        sts.range_ok   = span <= (fn_rd_input ? INPUT_LIM : HOLD_LIM);
        sts.is_write   = fn_write;
        sts.count_zero = (count_reg == 16'd0);
        sts.wr_pending = wr_pending_reg;
        sts.wr_last    = (wr_left_reg == HCW'(1));
        sts.rd_more    = (rd_left_reg != '0);
        sts.slot_free  = !out_valid_reg || out_ready;
    end

    // Write-multiple bookkeeping
    always_comb
    begin
        wr_pending_next  = wr_pending_reg;
        wr_ptr_next      = wr_ptr_reg;
        wr_left_next     = wr_left_reg;
        saved_start_next = saved_start_reg;
        saved_count_next = saved_count_reg;
        if (cmd.wr_setup)
        begin
            wr_pending_next  = (count_reg != 16'd0);
            wr_ptr_next      = HAW'(start_reg);
            wr_left_next     = HCW'(count_reg);
            saved_start_next = start_reg;
            saved_count_next = count_reg;
        end
        else if (cmd.hdr_clear)
        begin
            wr_pending_next = 1'b0;
            wr_left_next    = '0;
        end
        else if (cmd.wr_word)
        begin
            wr_ptr_next  = wr_ptr_reg + HAW'(1);
            wr_left_next = wr_left_reg - HCW'(1);
            if (wr_left_reg == HCW'(1))
            begin
                wr_pending_next = 1'b0;
            end
        end
    end

    // Read sequencing
    always_comb
    begin
        rd_addr_next  = rd_addr_reg;
        rd_left_next  = rd_left_reg;
        rd_input_next = rd_input_reg;
        if (cmd.rd_setup)
        begin
            rd_addr_next  = RAW'(start_reg);
            rd_left_next  = RAW'(count_reg);
            rd_input_next = fn_rd_input;
        end
        else if (cmd.rd_issue)
        begin
            rd_addr_next = rd_addr_reg + RAW'(1);
            rd_left_next = rd_left_reg - RAW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= msre_pkg::SLAVE_ADDR_RESET;
            wr_pending_reg    <= 1'b0;
            wr_ptr_reg        <= '0;
            wr_left_reg       <= '0;
            saved_start_reg   <= '0;
            saved_count_reg   <= '0;
            rd_addr_reg       <= '0;
            rd_left_reg       <= '0;
            rd_input_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                slave_address_reg <= slave_address;
            end
            wr_pending_reg  <= wr_pending_next;
            wr_ptr_reg      <= wr_ptr_next;
            wr_left_reg     <= wr_left_next;
            saved_start_reg <= saved_start_next;
            saved_count_reg <= saved_count_next;
            rd_addr_reg     <= rd_addr_next;
            rd_left_reg     <= rd_left_next;
            rd_input_reg    <= rd_input_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Store ports
    assign hold_wr_en   = cmd.wr_word || (cmd.load_hold && idx_in_hold);
    assign hold_wr_addr = cmd.wr_word ? wr_ptr_reg : HAW'(idx_reg);
    assign hold_rd_en   = cmd.rd_issue && !rd_input_reg;
    assign input_wr_en  = cmd.load_in && idx_in_input;
    assign input_rd_en  = cmd.rd_issue && rd_input_reg;

    msre_store #(
        .DEPTH (HOLD_DEPTH),
        .AW    (HAW)
    ) u_hold_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (hold_wr_en),
        .wr_addr (hold_wr_addr),
        .wr_data (word_reg),
        .rd_en   (hold_rd_en),
        .rd_addr (HAW'(rd_addr_reg)),
        .rd_data (hold_rd_data)
    );

    msre_store #(
        .DEPTH (INPUT_DEPTH),
        .AW    (IAW)
    ) u_input_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (input_wr_en),
        .wr_addr (IAW'(idx_reg)),
        .wr_data (word_reg),
        .rd_en   (input_rd_en),
        .rd_addr (IAW'(rd_addr_reg)),
        .rd_data (input_rd_data)
    );

    // Output beat formation
    always_comb
    begin
        out_kind_next       = 1'b0;
        out_function_next   = fn_reg;
        exception_code_next = msre_pkg::EXC_NONE;
        field_a_next        = 16'd0;
        field_b_next        = 16'd0;
        reg_word_next       = 16'd0;
        last_next           = 1'b1;
        unique case (cmd.emit_sel)
            msre_pkg::EMIT_EXC:
            begin
                out_function_next   = fn_reg + msre_pkg::EXC_FLAG;
                exception_code_next = sts.fn_legal ? msre_pkg::EXC_ADDRESS
                                                   : msre_pkg::EXC_FUNCTION;
            end
            msre_pkg::EMIT_RD_HDR:
            begin
                field_a_next = {count_reg[14:0], 1'b0};
                last_next    = sts.count_zero;
            end
            msre_pkg::EMIT_WR_ECHO:
            begin
                out_function_next = msre_pkg::FC_WRITE_MULTI;
                field_a_next      = saved_start_reg;
                field_b_next      = saved_count_reg;
            end
            msre_pkg::EMIT_DATA:
            begin
                out_kind_next = 1'b1;
                reg_word_next = rd_input_reg ? input_rd_data : hold_rd_data;
                last_next     = (rd_left_reg == '0);
            end
            default:
            begin
                out_kind_next = 1'b0;
            end
        endcase

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg       <= out_kind_next;
            out_station_reg    <= slave_address_reg;
            out_function_reg   <= out_function_next;
            exception_code_reg <= exception_code_next;
            field_a_reg        <= field_a_next;
            field_b_reg        <= field_b_next;
            reg_word_reg       <= reg_word_next;
            last_reg           <= last_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_kind       = out_kind_reg;
    assign out_station    = out_station_reg;
    assign out_function   = out_function_reg;
    assign exception_code = exception_code_reg;
    assign field_a        = field_a_reg;
    assign field_b        = field_b_reg;
    assign reg_word       = reg_word_reg;
    assign last           = last_reg;

    `MSRE_ASSERT_NOW(a_wr_word_pending, clk, rst_n, cmd.wr_word, wr_pending_reg)
    `MSRE_ASSERT_NOW(a_rd_issue_left, clk, rst_n, cmd.rd_issue, rd_left_reg != '0)
    `MSRE_ASSERT_NOW(a_hold_addr_range, clk, rst_n, hold_wr_en, 32'(hold_wr_addr) < HOLD_DEPTH)
    `MSRE_ASSERT_NEXT(a_wr_done, clk, rst_n, cmd.wr_word && sts.wr_last, !wr_pending_reg)

endmodule

// ===== design/msre_ctrl.sv =====
// Controller: sequences decode, response emission and register reads.
`include "modbus_slave_register_engine_macros.svh"

module msre_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  msre_pkg::dp_status_t sts,
    output msre_pkg::ctrl_cmd_t  cmd
);

    msre_pkg::state_t state_reg, state_next;
    msre_pkg::emit_t  emit_sel_reg, emit_sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= msre_pkg::ST_IDLE;
            emit_sel_reg <= msre_pkg::EMIT_EXC;
        end
        else
        begin
            state_reg    <= state_next;
            emit_sel_reg <= emit_sel_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next    = state_reg;
        emit_sel_next = emit_sel_reg;
        unique case (state_reg)
            msre_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = msre_pkg::ST_DECODE;
                end
            end
            msre_pkg::ST_DECODE:
            begin
                state_next = msre_pkg::ST_IDLE;
                unique case (sts.op)
                    msre_pkg::OP_HEADER:
                    begin
                        if (sts.addressed)
                        begin
                            if (!sts.fn_legal || !sts.range_ok)
                            begin
                                emit_sel_next = msre_pkg::EMIT_EXC;
                                state_next    = msre_pkg::ST_EMIT;
                            end
                            else if (sts.is_write)
                            begin
                                if (sts.count_zero)
                                begin
                                    emit_sel_next = msre_pkg::EMIT_WR_ECHO;
                                    state_next    = msre_pkg::ST_EMIT;
                                end
                            end
                            else
                            begin
                                emit_sel_next = msre_pkg::EMIT_RD_HDR;
                                state_next    = msre_pkg::ST_EMIT;
                            end
                        end
                    end
                    msre_pkg::OP_WRITE_WORD:
                    begin
                        if (sts.wr_pending && sts.wr_last)
                        begin
                            emit_sel_next = msre_pkg::EMIT_WR_ECHO;
                            state_next    = msre_pkg::ST_EMIT;
                        end
                    end
                    default:
                    begin
                        state_next = msre_pkg::ST_IDLE;
                    end
                endcase
            end
            msre_pkg::ST_EMIT:
            begin
                if (sts.slot_free)
                begin
                    if ((emit_sel_reg == msre_pkg::EMIT_RD_HDR) && !sts.count_zero)
                    begin
                        state_next = msre_pkg::ST_RD_ISSUE;
                    end
                    else
                    begin
                        state_next = msre_pkg::ST_IDLE;
                    end
                end
            end
            msre_pkg::ST_RD_ISSUE:
            begin
                state_next = msre_pkg::ST_RD_DATA;
            end
            msre_pkg::ST_RD_DATA:
            begin
                if (sts.slot_free && !sts.rd_more)
                begin
                    state_next = msre_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msre_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd          = '0;
        cmd.emit_sel = emit_sel_reg;
        unique case (state_reg)
            msre_pkg::ST_IDLE:
            begin
                cmd.take = in_valid;
            end
            msre_pkg::ST_DECODE:
            begin
                unique case (sts.op)
                    msre_pkg::OP_HEADER:
                    begin
                        if (sts.addressed)
                        begin
                            cmd.hdr_clear = 1'b1;
                            if (sts.fn_legal && sts.range_ok)
                            begin
                                cmd.wr_setup = sts.is_write;
                                cmd.rd_setup = !sts.is_write;
                            end
                        end
                    end
                    msre_pkg::OP_WRITE_WORD:
                    begin
                        cmd.wr_word = sts.wr_pending;
                    end
                    msre_pkg::OP_LOAD_INPUT:
                    begin
                        cmd.load_in = 1'b1;
                    end
                    msre_pkg::OP_LOAD_HOLD:
                    begin
                        cmd.load_hold = 1'b1;
                    end
                    default:
                    begin
                        cmd.load_in = 1'b0;
                    end
                endcase
            end
            msre_pkg::ST_EMIT:
            begin
                cmd.emit = sts.slot_free;
            end
            msre_pkg::ST_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
            end
            msre_pkg::ST_RD_DATA:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = msre_pkg::EMIT_DATA;
                    cmd.rd_issue = sts.rd_more;
                end
            end
            default:
            begin
                cmd.take = 1'b0;
            end
        endcase
    end

    assign in_ready = (state_reg == msre_pkg::ST_IDLE);

    `MSRE_ASSERT_NOW(a_emit_slot_free, clk, rst_n, cmd.emit, sts.slot_free)

endmodule

// ===== design/modbus_slave_register_engine.sv =====
// Top level of the Modbus slave register engine (functions 03, 04 and 0x10).
//
//  channel | signals                               | direction | beat
//  --------+---------------------------------------+-----------+-------------------------
//  in      | in_valid/in_ready + 7 request fields  | input     | header, data word, load
//  out     | out_valid/out_ready + 8 result fields | output    | response header or word
//  cfg     | cfg_valid/cfg_ready + slave_address   | input     | own station address
//
// A load or a stray data beat passes through accept and decode; a beat that answers
// with one header also passes through emit, which waits until the output register is free.
// A read of N registers goes on through the issue and data states: the registered store read
// port delivers one word a cycle while the output side keeps taking beats.
// Reset is asynchronous; per-entry valid bits make both stores read as zero at once,
// so there is no clearing pass.
// An output stall holds the sequencer; the input side stays not ready until it resumes.
module modbus_slave_register_engine #(
    parameter int HOLD_DEPTH  = msre_pkg::HOLD_DEPTH_DEF,
    parameter int INPUT_DEPTH = msre_pkg::INPUT_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  dest_address,
    input  logic [7:0]  function_code,
    input  logic [15:0] start_address,
    input  logic [15:0] register_count,
    input  logic [15:0] data_word,
    input  logic [4:0]  local_index,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_kind,
    output logic [7:0]  out_station,
    output logic [7:0]  out_function,
    output logic [1:0]  exception_code,
    output logic [15:0] field_a,
    output logic [15:0] field_b,
    output logic [15:0] reg_word,
    output logic        last,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  slave_address
);

    msre_pkg::ctrl_cmd_t  cmd;
    msre_pkg::dp_status_t sts;

    // Configuration beats land at once; the user is to send them only while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    // Controller: walks decode, emit and read states and drives datapath commands.
    msre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: holds the request, both stores, write progress and the output register.
    msre_datapath #(
        .HOLD_DEPTH  (HOLD_DEPTH),
        .INPUT_DEPTH (INPUT_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .opcode         (opcode),
        .dest_address   (dest_address),
        .function_code  (function_code),
        .start_address  (start_address),
        .register_count (register_count),
        .data_word      (data_word),
        .local_index    (local_index),
        .cfg_valid      (cfg_valid),
        .slave_address  (slave_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_kind       (out_kind),
        .out_station    (out_station),
        .out_function   (out_function),
        .exception_code (exception_code),
        .field_a        (field_a),
        .field_b        (field_b),
        .reg_word       (reg_word),
        .last           (last)
    );

endmodule
